// ----- hdl/iss_pkg.sv -----
// Shared types and constants of the indexed stack store.
// Holds the command and result words, opcode and status codes, and the byte mask helper.
// No dependencies.
package iss_pkg;

  localparam int ELEM_W = 64;
  localparam int SIZE_W = 4;
  localparam int LEN_W  = 9;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

  localparam logic [2:0] OP_PUSH      = 3'd0;
  localparam logic [2:0] OP_POP       = 3'd1;
  localparam logic [2:0] OP_READ_AT   = 3'd2;
  localparam logic [2:0] OP_READ_LAST = 3'd3;
  localparam logic [2:0] OP_REMOVE    = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_SIZE  = 2'd3;

  typedef struct packed {
    logic [2:0]        opcode;
    logic [7:0]        position;
    logic [SIZE_W-1:0] item_bytes;
    logic [ELEM_W-1:0] item_value;
  } cmd_word_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ELEM_W-1:0] read_value;
    logic [LEN_W-1:0]  length;
  } result_word_t;

  // Keep the low nbytes bytes; eight or more keeps the whole word.
  function automatic logic [ELEM_W-1:0] byte_mask(input logic [SIZE_W-1:0] nbytes);
    logic [ELEM_W-1:0] m;
    m = '0;
    for (int b = 0; b < 8; b++) begin
      if (SIZE_W'(b) < nbytes) begin
        m[8*b +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

endpackage

// ----- hdl/iss_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module iss_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/iss_ctrl.sv -----
// Sequencer of the indexed stack store: decodes commands, owns the element count,
// drives the element RAM and walks the shift-down of a remove one entry per cycle.
// Depends on iss_pkg and iss_ram.
module iss_ctrl #(
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  iss_pkg::cmd_word_t       cmd,
  input  logic [iss_pkg::SIZE_W-1:0] element_bytes,
  output logic                     busy,
  output logic                     done,
  output iss_pkg::result_word_t    result
);

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > 8) ? CW : 8;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_READ  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;

  logic [1:0]    state, state_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] ptr, ptr_next;
  logic          pend, pend_next;
  logic [AW-1:0] waddr, waddr_next;
  logic          done_next;
  iss_pkg::result_word_t result_next;

  logic                      ram_we;
  logic [AW-1:0]             ram_waddr;
  logic [iss_pkg::ELEM_W-1:0] ram_wdata;
  logic [AW-1:0]             ram_raddr;
  logic [iss_pkg::ELEM_W-1:0] ram_rdata;

  logic [iss_pkg::ELEM_W-1:0] mask;
  logic [CW-1:0] cnt_inc, cnt_dec;
  logic          pos_bad, empty, full, size_bad;

  assign mask     = iss_pkg::byte_mask(element_bytes);
  assign cnt_inc  = count + CW'(1);
  assign cnt_dec  = count - CW'(1);
  assign pos_bad  = CMPW'(cmd.position) >= CMPW'(count);
  assign empty    = (count == '0);
  assign full     = (count == CW'(DEPTH));
  assign size_bad = (cmd.item_bytes != element_bytes);
  assign busy     = (state != S_IDLE);

  iss_ram #(
    .WIDTH (iss_pkg::ELEM_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next  = state;
    count_next  = count;
    ptr_next    = ptr;
    pend_next   = 1'b0;
    waddr_next  = waddr;
    done_next   = 1'b0;
    result_next = result;
    ram_we      = 1'b0;
    ram_waddr   = AW'(count);
    ram_wdata   = cmd.item_value & mask;
    ram_raddr   = AW'(cmd.position);

    unique case (state)
      S_IDLE: begin
        if (start) begin
          result_next.status     = iss_pkg::ST_OK;
          result_next.read_value = '0;
          result_next.length     = iss_pkg::LEN_W'(count);
          unique case (cmd.opcode)
            iss_pkg::OP_PUSH: begin
              done_next = 1'b1;
              if (size_bad) begin
                result_next.status = iss_pkg::ST_SIZE;
              end else if (full) begin
                result_next.status = iss_pkg::ST_FULL;
              end else begin
                ram_we             = 1'b1;
                count_next         = cnt_inc;
                result_next.length = iss_pkg::LEN_W'(cnt_inc);
              end
            end
            iss_pkg::OP_POP: begin
              done_next = 1'b1;
              if (empty) begin
                result_next.status = iss_pkg::ST_RANGE;
              end else begin
                count_next         = cnt_dec;
                result_next.length = iss_pkg::LEN_W'(cnt_dec);
              end
            end
            iss_pkg::OP_READ_AT: begin
              if (pos_bad) begin
                result_next.status = iss_pkg::ST_RANGE;
                done_next          = 1'b1;
              end else begin
                state_next = S_READ;
              end
            end
            iss_pkg::OP_READ_LAST: begin
              if (empty) begin
                result_next.status = iss_pkg::ST_RANGE;
                done_next          = 1'b1;
              end else begin
                ram_raddr  = AW'(cnt_dec);
                state_next = S_READ;
              end
            end
            iss_pkg::OP_REMOVE: begin
              if (pos_bad) begin
                result_next.status = iss_pkg::ST_RANGE;
                done_next          = 1'b1;
              end else begin
                ptr_next   = CW'(cmd.position) + CW'(1);
                state_next = S_SHIFT;
              end
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        result_next.read_value = ram_rdata & mask;
        done_next              = 1'b1;
        state_next             = S_IDLE;
      end
      S_SHIFT: begin
        // write back the word read last cycle one place lower
        if (pend) begin
          ram_we    = 1'b1;
          ram_waddr = waddr;
          ram_wdata = ram_rdata;
        end
        if (ptr < count) begin
          ram_raddr  = AW'(ptr);
          ptr_next   = ptr + CW'(1);
          pend_next  = 1'b1;
          waddr_next = AW'(ptr - CW'(1));
        end else if (!pend) begin
          count_next         = cnt_dec;
          result_next.length = iss_pkg::LEN_W'(cnt_dec);
          done_next          = 1'b1;
          state_next         = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      pend  <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      pend  <= pend_next;
      done  <= done_next;
    end
    ptr    <= ptr_next;
    waddr  <= waddr_next;
    result <= result_next;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("element count beyond capacity");

  a_len_match: assert property (@(posedge clk) disable iff (rst)
    done |-> result.length == iss_pkg::LEN_W'(count))
    else $error("reported length differs from element count");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> state == S_IDLE)
    else $error("result issued while sequencer is busy");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.status != iss_pkg::ST_OK) |-> result.read_value == '0)
    else $error("read data on a failed operation");

  a_shift_ptr: assert property (@(posedge clk) disable iff (rst)
    state == S_SHIFT |-> (ptr <= count && ptr != '0))
    else $error("shift pointer out of range");

endmodule

// ----- hdl/indexed_stack_store_unit.sv -----
// Indexed stack store: DEPTH 64-bit entries used as a stack with indexed read and remove.
// A command is taken when start is high and busy is low; its one result appears on result
// with done high for exactly one cycle and must be taken then, since the receiver cannot
// stall. Push, pop, every error and the unused opcodes answer in the cycle after the
// command; reads answer after the S_READ state. A remove at position p walks the tail
// through the single RAM read port, one entry per cycle, and answers once the walk is
// done. element_bytes may be written through cfg_* while busy and start are low.
// Depends on iss_pkg, iss_ctrl and iss_ram.
module indexed_stack_store_unit #(
  parameter int DEPTH = 256
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  iss_pkg::cmd_word_t             cmd,
  output logic                           busy,
  output logic                           done,
  output iss_pkg::result_word_t          result,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [iss_pkg::SIZE_W-1:0]     cfg_data
);

  logic [iss_pkg::SIZE_W-1:0] element_bytes;

  // hold off register writes while a command is in flight or being taken
  assign cfg_ready = ~busy & ~start;

  always_ff @(posedge clk) begin
    if (rst) begin
      element_bytes <= iss_pkg::SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      element_bytes <= cfg_data;
    end
  end

  iss_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .cmd           (cmd),
    .element_bytes (element_bytes),
    .busy          (busy),
    .done          (done),
    .result        (result)
  );

endmodule

// ----- tb/sv/tb_indexed_stack_store_unit.sv -----
// Self-checking testbench for indexed_stack_store_unit: a directed table, then random
// phases at several element sizes, each result held to a typed row or a store model.
// Depends on iss_pkg and the indexed_stack_store_unit RTL.
module tb_indexed_stack_store_unit;

  localparam int STORE_DEPTH = 256;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int NUM_PHASES  = 10;
  localparam int CMD_W       = $bits(iss_pkg::cmd_word_t);

  localparam logic [2:0] OP_SPARE0 = 3'd5;
  localparam logic [2:0] OP_SPARE1 = 3'd6;
  localparam logic [2:0] OP_SPARE2 = 3'd7;

  typedef enum logic [1:0] {MIX, FILL, DRAIN} phase_kind_t;

  typedef struct packed {
    logic [2:0]                 op;
    logic [7:0]                 pos;
    logic [iss_pkg::SIZE_W-1:0] nb;
    logic [iss_pkg::ELEM_W-1:0] val;
    logic                       typed;
    logic [1:0]                 st;
    logic [iss_pkg::ELEM_W-1:0] rv;
    logic [iss_pkg::LEN_W-1:0]  len;
  } plan_row_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       start = 1'b0;
  iss_pkg::cmd_word_t         cmd = '0;
  logic                       busy;
  logic                       done;
  iss_pkg::result_word_t      result;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [iss_pkg::SIZE_W-1:0] cfg_data = '0;

  // store model state
  logic [iss_pkg::ELEM_W-1:0] entries [STORE_DEPTH];
  int                         held = 0;
  logic [iss_pkg::SIZE_W-1:0] cur_bytes = iss_pkg::SIZE_RESET;

  iss_pkg::result_word_t      pending [$];
  iss_pkg::result_word_t      want;
  int                         errors = 0;
  int                         cycles = 0;
  int                         n_cmds = 0;
  int                         n_results = 0;
  int                         peak = 0;
  int                         n_range = 0;
  int                         n_full = 0;
  int                         n_size = 0;
  plan_row_t                  plan [25];

  indexed_stack_store_unit #(.DEPTH(STORE_DEPTH)) DUT (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cmd       (cmd),
    .busy      (busy),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending.size());
      $display("tb_indexed_stack_store_unit: done, errors");
      $finish;
    end
  end

  function automatic logic [iss_pkg::ELEM_W-1:0] size_mask(
    input logic [iss_pkg::SIZE_W-1:0] nbytes);
    if (nbytes >= 4'd8) begin
      return '1;
    end
    return (64'd1 << (8 * nbytes)) - 64'd1;
  endfunction

  // Apply one command word to the model and return the word the block should answer.
  function automatic iss_pkg::result_word_t apply_command(input iss_pkg::cmd_word_t c);
    iss_pkg::result_word_t r;
    r = '0;
    r.status = iss_pkg::ST_OK;
    case (c.opcode)
      iss_pkg::OP_PUSH: begin
        if (c.item_bytes != cur_bytes) begin
          r.status = iss_pkg::ST_SIZE;
        end else if (held >= STORE_DEPTH) begin
          r.status = iss_pkg::ST_FULL;
        end else begin
          entries[held] = c.item_value & size_mask(cur_bytes);
          held++;
        end
      end
      iss_pkg::OP_POP: begin
        if (held == 0) r.status = iss_pkg::ST_RANGE;
        else held--;
      end
      iss_pkg::OP_READ_AT: begin
        if (int'(c.position) >= held) r.status = iss_pkg::ST_RANGE;
        else r.read_value = entries[c.position] & size_mask(cur_bytes);
      end
      iss_pkg::OP_READ_LAST: begin
        if (held == 0) r.status = iss_pkg::ST_RANGE;
        else r.read_value = entries[held-1] & size_mask(cur_bytes);
      end
      iss_pkg::OP_REMOVE: begin
        if (int'(c.position) >= held) begin
          r.status = iss_pkg::ST_RANGE;
        end else begin
          for (int i = int'(c.position); i + 1 < held; i++) entries[i] = entries[i+1];
          held--;
        end
      end
      default: ;
    endcase
    r.length = iss_pkg::LEN_W'(held);
    return r;
  endfunction

  // Random command shaped by phase: mostly in-range positions and matching sizes.
  function automatic iss_pkg::cmd_word_t make_command(input phase_kind_t kind);
    iss_pkg::cmd_word_t c;
    int pick;
    int t_push, t_bad, t_pop, t_rdat, t_rdlast, t_rm;
    case (kind)
      FILL: begin
        t_push = 88; t_bad = 92; t_pop = 93; t_rdat = 96; t_rdlast = 98; t_rm = 100;
      end
      DRAIN: begin
        t_push = 10; t_bad = 12; t_pop = 40; t_rdat = 55; t_rdlast = 60; t_rm = 97;
      end
      default: begin
        t_push = 35; t_bad = 40; t_pop = 55; t_rdat = 70; t_rdlast = 80; t_rm = 95;
      end
    endcase
    c.position   = 8'($urandom);
    c.item_bytes = iss_pkg::SIZE_W'($urandom);
    c.item_value = {$urandom, $urandom};
    pick = $urandom_range(0, 99);
    if (pick < t_push) begin
      c.opcode = iss_pkg::OP_PUSH;
      c.item_bytes = cur_bytes;
    end else if (pick < t_bad) begin
      c.opcode = iss_pkg::OP_PUSH;
      c.item_bytes = cur_bytes + iss_pkg::SIZE_W'($urandom_range(1, 15));
    end else if (pick < t_pop) begin
      c.opcode = iss_pkg::OP_POP;
    end else if (pick < t_rdat) begin
      c.opcode = iss_pkg::OP_READ_AT;
    end else if (pick < t_rdlast) begin
      c.opcode = iss_pkg::OP_READ_LAST;
    end else if (pick < t_rm) begin
      c.opcode = iss_pkg::OP_REMOVE;
    end else begin
      c.opcode = 3'($urandom_range(OP_SPARE0, OP_SPARE2));
    end
    if ((c.opcode == iss_pkg::OP_READ_AT || c.opcode == iss_pkg::OP_REMOVE) && held > 0
        && $urandom_range(0, 4) != 0) begin
      c.position = 8'($urandom_range(0, held - 1));
    end
    return c;
  endfunction

  // Hold start until the block takes the word, then log what it should answer.
  task automatic issue(input iss_pkg::cmd_word_t c, input bit idle_ok, input bit typed,
                       input iss_pkg::result_word_t typed_r);
    iss_pkg::result_word_t r;
    if (idle_ok && $urandom_range(0, 5) == 0) begin
      start <= 1'b0;
      cmd <= CMD_W'({$urandom, $urandom, $urandom});
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    start <= 1'b1;
    cmd <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    r = apply_command(c);
    if (typed) r = typed_r;
    pending.push_back(r);
    n_cmds++;
    if (held > peak) peak = held;
    if (r.status == iss_pkg::ST_RANGE) n_range++;
    if (r.status == iss_pkg::ST_FULL) n_full++;
    if (r.status == iss_pkg::ST_SIZE) n_size++;
  endtask

  task automatic drain_and_write(input logic [iss_pkg::SIZE_W-1:0] nbytes);
    start <= 1'b0;
    while (pending.size() != 0 || busy) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= nbytes;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cur_bytes = nbytes;
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (done) begin
      n_results++;
      if (pending.size() == 0) begin
        $error("result word with nothing outstanding: %h", result);
        errors++;
      end else begin
        want = pending.pop_front();
        if (result.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, result.status);
          errors++;
        end
        if (result.read_value !== want.read_value) begin
          $error("read_value: expected %h, got %h", want.read_value, result.read_value);
          errors++;
        end
        if (result.length !== want.length) begin
          $error("length: expected %0d, got %0d", want.length, result.length);
          errors++;
        end
      end
    end
  end

  initial begin : stimulus
    iss_pkg::cmd_word_t         c;
    iss_pkg::result_word_t      tr;
    phase_kind_t                kind;
    int                         count;
    int                         w;
    logic [iss_pkg::SIZE_W-1:0] sizes [NUM_PHASES];

    sizes = '{4'd1, 4'd8, 4'd3, 4'd0, 4'd15, 4'd9, 4'd2, 4'd5, 4'd7, 4'd8};
    // element size is 8 out of reset; typed rows are read straight off the spec
    plan = '{
      '{iss_pkg::OP_POP,       8'd0,   4'd8,  64'd0, 1'b1,
        iss_pkg::ST_RANGE, 64'd0, 9'd0},
      '{iss_pkg::OP_READ_LAST, 8'd0,   4'd8,  64'd0, 1'b1,
        iss_pkg::ST_RANGE, 64'd0, 9'd0},
      '{iss_pkg::OP_READ_AT,   8'd0,   4'd8,  64'd0, 1'b1,
        iss_pkg::ST_RANGE, 64'd0, 9'd0},
      '{iss_pkg::OP_REMOVE,    8'd255, 4'd8,  64'd0, 1'b1,
        iss_pkg::ST_RANGE, 64'd0, 9'd0},
      '{iss_pkg::OP_PUSH,      8'd0,   4'd4,  64'd1, 1'b1,
        iss_pkg::ST_SIZE,  64'd0, 9'd0},
      '{iss_pkg::OP_PUSH,      8'd0,   4'd15, '1,    1'b1,
        iss_pkg::ST_SIZE,  64'd0, 9'd0},
      '{iss_pkg::OP_PUSH,      8'd0,   4'd0,  '1,    1'b1,
        iss_pkg::ST_SIZE,  64'd0, 9'd0},
      '{iss_pkg::OP_PUSH,      8'd0,   4'd8,  '1,    1'b1,
        iss_pkg::ST_OK,    64'd0, 9'd1},
      '{iss_pkg::OP_PUSH,      8'd0,   4'd8,  64'd0, 1'b1,
        iss_pkg::ST_OK,    64'd0, 9'd2},
      '{iss_pkg::OP_PUSH,      8'd255, 4'd8,  64'h0123456789ABCDEF, 1'b1,
        iss_pkg::ST_OK,    64'd0, 9'd3},
      '{iss_pkg::OP_READ_AT,   8'd0,   4'd8,  64'd0, 1'b1,
        iss_pkg::ST_OK,    '1,    9'd3},
      '{iss_pkg::OP_READ_AT,   8'd1,   4'd8,  '1,    1'b1,
        iss_pkg::ST_OK,    64'd0, 9'd3},
      '{iss_pkg::OP_READ_LAST, 8'd0,   4'd8,  64'd0, 1'b1,
        iss_pkg::ST_OK,    64'h0123456789ABCDEF, 9'd3},
      '{iss_pkg::OP_READ_AT,   8'd3,   4'd8,  64'd0, 1'b1,
        iss_pkg::ST_RANGE, 64'd0, 9'd3},
      '{iss_pkg::OP_READ_AT,   8'd255, 4'd8,  64'd0, 1'b1,
        iss_pkg::ST_RANGE, 64'd0, 9'd3},
      '{iss_pkg::OP_REMOVE,    8'd3,   4'd8,  64'd0, 1'b1,
        iss_pkg::ST_RANGE, 64'd0, 9'd3},
      '{OP_SPARE0,             8'd255, 4'd15, '1,    1'b1,
        iss_pkg::ST_OK,    64'd0, 9'd3},
      '{OP_SPARE1,             8'd0,   4'd8,  '1,    1'b1,
        iss_pkg::ST_OK,    64'd0, 9'd3},
      '{OP_SPARE2,             8'd2,   4'd0,  64'd0, 1'b1,
        iss_pkg::ST_OK,    64'd0, 9'd3},
      '{iss_pkg::OP_REMOVE,    8'd0,   4'd8,  64'd0, 1'b0,
        iss_pkg::ST_OK,    64'd0, 9'd0},
      '{iss_pkg::OP_READ_AT,   8'd0,   4'd8,  64'd0, 1'b0,
        iss_pkg::ST_OK,    64'd0, 9'd0},
      '{iss_pkg::OP_READ_LAST, 8'd0,   4'd8,  64'd0, 1'b0,
        iss_pkg::ST_OK,    64'd0, 9'd0},
      '{iss_pkg::OP_REMOVE,    8'd1,   4'd8,  64'd0, 1'b0,
        iss_pkg::ST_OK,    64'd0, 9'd0},
      '{iss_pkg::OP_POP,       8'd0,   4'd8,  64'd0, 1'b0,
        iss_pkg::ST_OK,    64'd0, 9'd0},
      '{iss_pkg::OP_POP,       8'd0,   4'd8,  64'd0, 1'b1,
        iss_pkg::ST_RANGE, 64'd0, 9'd0}
    };

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[k]) begin
      c.opcode     = plan[k].op;
      c.position   = plan[k].pos;
      c.item_bytes = plan[k].nb;
      c.item_value = plan[k].val;
      tr.status     = plan[k].st;
      tr.read_value = plan[k].rv;
      tr.length     = plan[k].len;
      issue(c, 1'b1, plan[k].typed, tr);
    end

    // each phase starts from an idle block with a fresh element size
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain_and_write(sizes[ph]);
      kind = (ph == 1) ? FILL : (ph == 3) ? DRAIN : MIX;
      count = (kind == FILL) ? 320 : (kind == DRAIN) ? 300 : 110;
      for (int n = 0; n < count; n++) begin
        c = make_command(kind);
        issue(c, ph < NUM_PHASES - 2, 1'b0, '0);
      end
    end

    start <= 1'b0;
    for (w = 0; w < 5000 && pending.size() != 0; w++) @(posedge clk);
    repeat (300) @(posedge clk);
    if (pending.size() != 0) begin
      $error("%0d expected results never arrived", pending.size());
      errors += pending.size();
    end

    $display("covered %0d commands and %0d results over %0d element size phases, deepest fill %0d",
             n_cmds, n_results, NUM_PHASES + 1, peak);
    $display("error statuses seen: %0d range, %0d full, %0d size mismatch",
             n_range, n_full, n_size);
    if (errors == 0) begin
      $display("tb_indexed_stack_store_unit: done, clean");
    end else begin
      $display("tb_indexed_stack_store_unit: done, errors");
    end
    $finish;
  end

endmodule
